// File: hdl/drsf_pkg.sv
package drsf_pkg;

   localparam int MaxBuffers  = 4;
   localparam int MaxElements = 64;
   localparam int BufW        = 2;
   localparam int ElemW       = 6;
   localparam int SlotW       = BufW + ElemW;
   localparam int Slots       = MaxBuffers * MaxElements;

   localparam logic [63:0] FnvPrime = 64'd1099511628211;
   localparam logic [63:0] FnvBasis = 64'd1469598103934665603;

   localparam logic [1:0] ReqWrite  = 2'd0;
   localparam logic [1:0] ReqRead   = 2'd1;
   localparam logic [1:0] ReqFlush  = 2'd2;
   localparam logic [1:0] ReqUnused = 2'd3;

   localparam logic [1:0] CsrBufferCount  = 2'd0;
   localparam logic [1:0] CsrElementSize  = 2'd1;
   localparam logic [1:0] CsrElementCount = 2'd2;

   typedef struct packed {
      logic        status;
      logic [63:0] read_data;
      logic [8:0]  run_offset;
      logic [9:0]  run_bytes;
      logic        any_dirty;
      logic [6:0]  dirty_count;
      logic [5:0]  first_dirty;
      logic [5:0]  last_dirty;
      logic [63:0] content_hash;
      logic        wrote;
      logic        last;
   } rsp_type;

   localparam rsp_type RspLastOnly = '{last: 1'b1, default: '0};

   function automatic logic [63:0] byte_mask(input logic [3:0] n);
      logic [63:0] m;
      m = '0;
      for (int k = 0; k < 8; k++) begin
         if (4'(k) < n) m[8*k +: 8] = 8'hff;
      end
      return m;
   endfunction

endpackage

// File: hdl/dirty_run_shadow_flush_core.sv
// Shadow store of up to 4 buffers x 64 elements in one synchronous RAM plus a
// dirty-mark RAM. After reset a clearing pass over all 256 slots writes the
// store to zero and the marks to one; no request is taken meanwhile. Words are
// taken one at a time and a new one only after the previous result is in the
// output register. A read or write passes an address state and a memory-data
// state, then scans the buffer's marks for any_dirty, a read and a check state
// per element, up to the first dirty one (no scan for a word whose buffer is not
// in use). A flush reads each element in turn, folds the index and data bytes
// of each dirty element (4+element_size bytes) into an FNV-1a-style hash with a
// non-standard offset basis through the drsf_fnv xor-and-multiply unit, spends a
// run-end state on each run closed (held while the previous run waits on
// rsp_tready), and, if any run was found, clears the buffer's element_count marks.
module dirty_run_shadow_flush_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [6:0]   csr_wdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [79:0]  req_tdata,  // req_type, buffer_index, element_index, write_data, data_bytes
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [175:0] rsp_tdata,  // status, read_data, run_offset, run_bytes, any_dirty,
                                    // dirty_count, first_dirty, last_dirty, content_hash, wrote
   output logic         rsp_tlast
);
   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_RW_RD, ST_RW_DO, ST_SCAN_RD, ST_SCAN_EL, ST_FOLD,
      ST_FOLD_WT, ST_RUN_END, ST_CLR_MARKS, ST_DIRTY_RD, ST_DIRTY_CHK, ST_OUT
   } state_type;

   state_type state_ff;
   logic [2:0] bcnt_ff;
   logic [3:0] esz_ff;
   logic [6:0] ecnt_ff;

   logic [63:0] mem [drsf_pkg::Slots];
   logic        mark [drsf_pkg::Slots];
   logic [63:0] rd_data_ff;
   logic        rd_mark_ff;
   logic        mem_we, mark_we, mark_wv;
   logic [drsf_pkg::SlotW-1:0] mem_addr;
   logic [63:0] mem_wd;

   logic [1:0]  rq_type_ff;
   logic [1:0]  rq_buf_ff;
   logic [5:0]  rq_elem_ff;
   logic [63:0] rq_data_ff;
   logic [3:0]  rq_bytes_ff;

   logic [8:0]  clr_ff;
   logic [6:0]  i_ff;
   logic [3:0]  k_ff;
   logic        in_run_ff, any_run_ff, pend_ff;
   logic [5:0]  start_ff, first_ff, lastd_ff;
   logic [6:0]  cnt_ff;
   logic [63:0] elem_ff, hash_ff;
   drsf_pkg::rsp_type out_ff, pend_rsp_ff;
   logic        out_v_ff;

   logic [2:0] nb;
   logic [3:0] es;
   logic [6:0] ec;
   logic       buf_ok, rw_ok;
   logic       out_free, out_load;
   logic [2:0] f_sel;
   drsf_pkg::rsp_type rw_rsp, run_rsp, sum_rsp;

   logic        f_start, f_done;
   logic [7:0]  f_byte;
   logic [63:0] f_hash;

   always_comb begin
      nb = (bcnt_ff > 3'(drsf_pkg::MaxBuffers)) ? 3'(drsf_pkg::MaxBuffers) : bcnt_ff;
      es = (esz_ff > 4'd8) ? 4'd8 : esz_ff;
      ec = (ecnt_ff > 7'(drsf_pkg::MaxElements)) ? 7'(drsf_pkg::MaxElements) : ecnt_ff;
      buf_ok = ({1'b0, rq_buf_ff} < nb) && es != 4'd0 && ec != 7'd0;
      rw_ok = buf_ok && {1'b0, rq_elem_ff} < ec &&
              (rq_type_ff == drsf_pkg::ReqRead || rq_bytes_ff == es);
      // bytes 0..3 are the element index, then the element bytes
      f_sel = 3'(k_ff - 4'd4);
      if (k_ff < 4'd4) f_byte = (k_ff == 4'd0) ? {2'd0, i_ff[5:0]} : 8'd0;
      else             f_byte = elem_ff[8*f_sel +: 8];
      out_free = !out_v_ff || rsp_tready;

      rw_rsp = drsf_pkg::RspLastOnly;
      rw_rsp.status = !(rw_ok && (rq_type_ff == drsf_pkg::ReqWrite ||
                                  rq_type_ff == drsf_pkg::ReqRead));
      if (rq_type_ff == drsf_pkg::ReqRead && rw_ok)
         rw_rsp.read_data = rd_data_ff & drsf_pkg::byte_mask(es);

      run_rsp = '0;
      run_rsp.run_offset = 9'(10'(start_ff) * 10'(es));
      run_rsp.run_bytes = 10'((11'(lastd_ff) + 11'd1 - 11'(start_ff)) * 11'(es));
      run_rsp.wrote = 1'b1;

      sum_rsp = pend_rsp_ff;
      sum_rsp.dirty_count = cnt_ff;
      sum_rsp.first_dirty = first_ff;
      sum_rsp.last_dirty = lastd_ff;
      sum_rsp.content_hash = (hash_ff == '0) ? 64'd1 : hash_ff;
      sum_rsp.last = 1'b1;
   end

   drsf_fnv u_fnv (
      .clock   (clock),
      .start   (f_start),
      .hash_in (hash_ff),
      .byte_in (f_byte),
      .done    (f_done),
      .hash_out(f_hash)
   );

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= mem_wd;
      if (mark_we) mark[mem_addr] <= mark_wv;
      rd_data_ff <= mem[mem_addr];
      rd_mark_ff <= mark[mem_addr];
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = out_v_ff;
   assign rsp_tlast  = out_ff.last;
   assign rsp_tdata  = {7'd0, out_ff.wrote, out_ff.content_hash, out_ff.last_dirty,
                        out_ff.first_dirty, out_ff.dirty_count, out_ff.any_dirty,
                        out_ff.run_bytes, out_ff.run_offset, out_ff.read_data,
                        out_ff.status};

   always_comb begin
      mem_we = 1'b0; mark_we = 1'b0; mark_wv = 1'b0; mem_wd = '0; f_start = 1'b0;
      out_load = 1'b0;
      mem_addr = {rq_buf_ff, rq_elem_ff};
      unique case (state_ff)
         ST_CLEAR: begin
            mem_addr = clr_ff[7:0]; mem_we = 1'b1; mark_we = 1'b1; mark_wv = 1'b1;
         end
         ST_RW_DO: begin
            if (rq_type_ff == drsf_pkg::ReqWrite && rw_ok) begin
               mem_we = 1'b1; mark_we = 1'b1; mark_wv = 1'b1;
               mem_wd = rq_data_ff & drsf_pkg::byte_mask(es);
            end
         end
         ST_SCAN_RD, ST_DIRTY_RD, ST_CLR_MARKS: begin
            mem_addr = {rq_buf_ff, i_ff[5:0]};
            if (state_ff == ST_CLR_MARKS) mark_we = 1'b1;
         end
         ST_FOLD: f_start = 1'b1;
         // the previously closed run leaves as the new one is closed
         ST_RUN_END: out_load = pend_ff && out_free;
         ST_OUT: out_load = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR; clr_ff <= '0; out_v_ff <= 1'b0;
         bcnt_ff <= 3'd1; esz_ff <= 4'd8; ecnt_ff <= 7'd64;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               drsf_pkg::CsrBufferCount:  bcnt_ff <= csr_wdata[2:0];
               drsf_pkg::CsrElementSize:  esz_ff  <= csr_wdata[3:0];
               drsf_pkg::CsrElementCount: ecnt_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (out_load) begin
            out_ff <= pend_rsp_ff; out_v_ff <= 1'b1;
         end else if (out_v_ff && rsp_tready) out_v_ff <= 1'b0;
         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 9'd1;
               if (clr_ff == 9'(drsf_pkg::Slots - 1)) state_ff <= ST_IDLE;
            end
            ST_IDLE: if (req_tvalid) begin
               rq_type_ff  <= req_tdata[1:0];
               rq_buf_ff   <= req_tdata[3:2];
               rq_elem_ff  <= req_tdata[9:4];
               rq_data_ff  <= req_tdata[73:10];
               rq_bytes_ff <= req_tdata[77:74];
               state_ff    <= ST_RW_RD;
            end
            ST_RW_RD: begin
               pend_rsp_ff <= drsf_pkg::RspLastOnly;
               if (rq_type_ff == drsf_pkg::ReqFlush && buf_ok) begin
                  i_ff <= '0; in_run_ff <= 1'b0; any_run_ff <= 1'b0; pend_ff <= 1'b0;
                  cnt_ff <= '0; hash_ff <= drsf_pkg::FnvBasis;
                  state_ff <= ST_SCAN_RD;
               end else state_ff <= ST_RW_DO;
            end
            ST_RW_DO: begin
               pend_rsp_ff <= rw_rsp;
               i_ff <= '0;
               state_ff <= buf_ok ? ST_DIRTY_RD : ST_OUT;
            end
            ST_DIRTY_RD: state_ff <= ST_DIRTY_CHK;
            ST_DIRTY_CHK: begin
               if (rd_mark_ff) begin
                  pend_rsp_ff.any_dirty <= 1'b1; state_ff <= ST_OUT;
               end else if (i_ff + 7'd1 >= ec) state_ff <= ST_OUT;
               else begin
                  i_ff <= i_ff + 7'd1; state_ff <= ST_DIRTY_RD;
               end
            end
            ST_SCAN_RD: begin
               if (i_ff < ec) state_ff <= ST_SCAN_EL;
               else if (in_run_ff) state_ff <= ST_RUN_END;
               else if (any_run_ff) begin
                  i_ff <= '0; state_ff <= ST_CLR_MARKS;
               end else state_ff <= ST_OUT;
            end
            ST_SCAN_EL: begin
               if (rd_mark_ff) begin
                  if (!in_run_ff) begin
                     start_ff <= i_ff[5:0];
                     if (!any_run_ff) first_ff <= i_ff[5:0];
                  end
                  in_run_ff <= 1'b1; elem_ff <= rd_data_ff; k_ff <= '0;
                  cnt_ff <= cnt_ff + 7'd1; lastd_ff <= i_ff[5:0];
                  state_ff <= ST_FOLD;
               end else begin
                  i_ff <= i_ff + 7'd1;
                  state_ff <= in_run_ff ? ST_RUN_END : ST_SCAN_RD;
               end
            end
            ST_FOLD: state_ff <= ST_FOLD_WT;
            ST_FOLD_WT: if (f_done) begin
               hash_ff <= f_hash;
               if (k_ff + 4'd1 < 4'd4 + es) begin
                  k_ff <= k_ff + 4'd1; state_ff <= ST_FOLD;
               end else begin
                  i_ff <= i_ff + 7'd1; state_ff <= ST_SCAN_RD;
               end
            end
            ST_RUN_END: if (!pend_ff || out_free) begin
               // the newest run is held back to carry the summary
               pend_rsp_ff <= run_rsp;
               pend_ff <= 1'b1; any_run_ff <= 1'b1; in_run_ff <= 1'b0;
               if (i_ff >= ec) begin
                  i_ff <= '0; state_ff <= ST_CLR_MARKS;
               end else state_ff <= ST_SCAN_RD;
            end
            ST_CLR_MARKS: begin
               if (i_ff + 7'd1 >= ec) begin
                  pend_rsp_ff <= sum_rsp;
                  state_ff <= ST_OUT;
               end else i_ff <= i_ff + 7'd1;
            end
            ST_OUT: if (out_free) state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

// File: hdl/drsf_fnv.sv
// One FNV-1a byte fold: a registered xor, then a multiply as four 16-bit slice products that are registered and summed.
module drsf_fnv (
   input  logic        clock,
   input  logic        start,
   input  logic [63:0] hash_in,
   input  logic [7:0]  byte_in,
   output logic        done,
   output logic [63:0] hash_out
);
   localparam logic [63:0] FnvPrimeLow = drsf_pkg::FnvPrime;

   logic [63:0] x_ff, x_in;
   logic [63:0] p_ff [4];
   logic [63:0] p_in [4];
   logic        s1_ff, s2_ff;

   always_comb begin
      x_in = hash_in ^ {56'd0, byte_in};
      for (int k = 0; k < 4; k++) begin
         // prime = 0x100_0000_01b3 ; product mod 2^64 from 16-bit slices of x
         p_in[k] = 64'(({48'd0, x_ff[16*k +: 16]} * FnvPrimeLow) << (16*k));
      end
      hash_out = p_ff[0] + p_ff[1] + p_ff[2] + p_ff[3];
   end

   always_ff @(posedge clock) begin
      x_ff  <= x_in;
      p_ff  <= p_in;
      s1_ff <= start;
      s2_ff <= s1_ff;
   end

   assign done = s2_ff;
endmodule

// File: tb/dirty_run_shadow_flush_core_test.sv
module dirty_run_shadow_flush_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         csr_we = 1'b0;
   logic [1:0]   csr_index = '0;
   logic [6:0]   csr_wdata = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [79:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [175:0] rsp_tdata;
   logic         rsp_tlast;

   dirty_run_shadow_flush_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // req_type, buffer_index, element_index, write_data, data_bytes
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // status, read_data, run_offset, run_bytes, any_dirty,
                                 // dirty_count, first_dirty, last_dirty, content_hash, wrote
      .rsp_tlast  (rsp_tlast)
   );

   // shadow copy of the block
   logic [63:0] mirror_data [drsf_pkg::Slots];
   logic        mirror_dirty [drsf_pkg::Slots];
   logic [2:0]  buf_count_reg;
   logic [3:0]  elem_size_reg;
   logic [6:0]  elem_count_reg;

   drsf_pkg::rsp_type pending_rsp [$];
   int          mismatch_count = 0;
   int          send_gap_pct = 0;
   int          rsp_stall_pct = 0;

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #100ms;
      $display("TEST FAILED");
      $finish;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   function automatic int nb_eff();
      return buf_count_reg > 3'(drsf_pkg::MaxBuffers) ? drsf_pkg::MaxBuffers
                                                       : int'(buf_count_reg);
   endfunction

   function automatic int es_eff();
      return elem_size_reg > 4'd8 ? 8 : int'(elem_size_reg);
   endfunction

   function automatic int ec_eff();
      return elem_count_reg > 7'(drsf_pkg::MaxElements) ? drsf_pkg::MaxElements
                                                         : int'(elem_count_reg);
   endfunction

   function automatic logic [63:0] size_mask(int n);
      return n >= 8 ? '1 : (64'd1 << (8 * n)) - 64'd1;
   endfunction

   function automatic logic buf_has_dirty(int b);
      for (int i = 0; i < ec_eff(); i++)
         if (mirror_dirty[b * drsf_pkg::MaxElements + i]) return 1'b1;
      return 1'b0;
   endfunction

   // expected results of one accepted word
   task automatic predict_response(logic [1:0] rt, logic [1:0] b, logic [5:0] e,
                                   logic [63:0] wd, logic [3:0] db);
      int          nb, es, ec, i, start, n, cnt, first, lastd, slot;
      logic        buf_ok, ok;
      logic [63:0] h, v;
      drsf_pkg::rsp_type r;
      drsf_pkg::rsp_type runs [$];
      nb = nb_eff();
      es = es_eff();
      ec = ec_eff();
      buf_ok = (b < nb) && es != 0 && ec != 0;
      r = '0;
      r.last = 1'b1;
      if (rt == drsf_pkg::ReqWrite || rt == drsf_pkg::ReqRead) begin
         ok = buf_ok && e < ec && (rt == drsf_pkg::ReqRead || db == es);
         slot = b * drsf_pkg::MaxElements + e;
         if (ok) begin
            if (rt == drsf_pkg::ReqWrite) begin
               mirror_data[slot] = wd & size_mask(es);
               mirror_dirty[slot] = 1'b1;
            end else begin
               r.read_data = mirror_data[slot] & size_mask(es);
            end
         end
         r.status = !ok;
         r.any_dirty = buf_ok && buf_has_dirty(b);
         pending_rsp.push_back(r);
      end else if (rt == drsf_pkg::ReqFlush && buf_ok) begin
         h = drsf_pkg::FnvBasis;
         i = 0; n = 0; cnt = 0; first = 0; lastd = 0;
         while (i < ec) begin
            if (!mirror_dirty[b * drsf_pkg::MaxElements + i]) begin
               i++;
               continue;
            end
            start = i;
            while (i < ec && mirror_dirty[b * drsf_pkg::MaxElements + i]) begin
               v = mirror_data[b * drsf_pkg::MaxElements + i];
               for (int k = 0; k < 4; k++)
                  h = (h ^ 64'((i >> (8 * k)) & 8'hff)) * drsf_pkg::FnvPrime;
               for (int k = 0; k < es; k++) h = (h ^ 64'(v[8*k +: 8])) * drsf_pkg::FnvPrime;
               cnt++;
               i++;
            end
            if (n == 0) first = start;
            lastd = i - 1;
            r = '0;
            r.run_offset = 9'(start * es);
            r.run_bytes = 10'((i - start) * es);
            r.wrote = 1'b1;
            runs.push_back(r);
            n++;
         end
         if (n == 0) begin
            r = '0;
            r.last = 1'b1;
            runs.push_back(r);
         end else begin
            runs[n-1].dirty_count = 7'(cnt);
            runs[n-1].first_dirty = 6'(first);
            runs[n-1].last_dirty = 6'(lastd);
            runs[n-1].content_hash = h != 0 ? h : 64'd1;
            runs[n-1].last = 1'b1;
            for (int j = 0; j < ec; j++) mirror_dirty[b * drsf_pkg::MaxElements + j] = 1'b0;
         end
         foreach (runs[j]) pending_rsp.push_back(runs[j]);
      end else begin
         r.status = 1'b1;
         r.any_dirty = buf_ok && buf_has_dirty(b);
         pending_rsp.push_back(r);
      end
   endtask

   task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("%0t mismatch %s: expected %h got %h", $realtime, name, exp_v, act_v);
      end
   endtask

   always @(posedge clock) begin
      drsf_pkg::rsp_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status       = rsp_tdata[0];
         got.read_data    = rsp_tdata[64:1];
         got.run_offset   = rsp_tdata[73:65];
         got.run_bytes    = rsp_tdata[83:74];
         got.any_dirty    = rsp_tdata[84];
         got.dirty_count  = rsp_tdata[91:85];
         got.first_dirty  = rsp_tdata[97:92];
         got.last_dirty   = rsp_tdata[103:98];
         got.content_hash = rsp_tdata[167:104];
         got.wrote        = rsp_tdata[168];
         got.last         = rsp_tlast;
         if (pending_rsp.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("%0t unexpected word", $realtime);
         end else begin
            want = pending_rsp.pop_front();
            check_field("status", want.status, got.status);
            check_field("read_data", want.read_data, got.read_data);
            check_field("run_offset", want.run_offset, got.run_offset);
            check_field("run_bytes", want.run_bytes, got.run_bytes);
            check_field("any_dirty", want.any_dirty, got.any_dirty);
            check_field("dirty_count", want.dirty_count, got.dirty_count);
            check_field("first_dirty", want.first_dirty, got.first_dirty);
            check_field("last_dirty", want.last_dirty, got.last_dirty);
            check_field("content_hash", want.content_hash, got.content_hash);
            check_field("wrote", want.wrote, got.wrote);
            check_field("last", want.last, got.last);
         end
      end
   end

   task automatic send_request(logic [1:0] rt, logic [1:0] b, logic [5:0] e,
                               logic [63:0] wd, logic [3:0] db);
      @(negedge clock);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = {2'b00, db, wd, e, b, rt};
      do @(posedge clock); while (!(req_tvalid && req_tready));
      predict_response(rt, b, e, wd, db);
   endtask

   task automatic drain_responses();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [6:0] val);
      drain_responses();
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         drsf_pkg::CsrBufferCount:  buf_count_reg = val[2:0];
         drsf_pkg::CsrElementSize:  elem_size_reg = val[3:0];
         drsf_pkg::CsrElementCount: elem_count_reg = val;
         default: ;
      endcase
   endtask

   task automatic set_layout(logic [6:0] bufs, logic [6:0] size, logic [6:0] count);
      write_csr(drsf_pkg::CsrBufferCount, bufs);
      write_csr(drsf_pkg::CsrElementSize, size);
      write_csr(drsf_pkg::CsrElementCount, count);
   endtask

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   task automatic test_reset_flush();
      // everything starts dirty: one run spanning the whole buffer
      send_request(drsf_pkg::ReqRead, 2'd0, 6'd63, '0, 4'd0);
      send_request(drsf_pkg::ReqFlush, 2'd0, 6'd0, '0, 4'd0);
      send_request(drsf_pkg::ReqFlush, 2'd0, 6'd0, '0, 4'd0);
   endtask

   task automatic test_write_read();
      send_request(drsf_pkg::ReqWrite, 2'd0, 6'd0, '1, 4'd8);
      send_request(drsf_pkg::ReqWrite, 2'd0, 6'd63, 64'h0123_4567_89ab_cdef, 4'd8);
      send_request(drsf_pkg::ReqRead, 2'd0, 6'd0, '0, 4'd15);
      send_request(drsf_pkg::ReqRead, 2'd0, 6'd63, '0, 4'd0);
      send_request(drsf_pkg::ReqFlush, 2'd0, 6'd0, '0, 4'd0);
   endtask

   task automatic test_rejects();
      set_layout(7'd4, 7'd3, 7'd40);
      send_request(drsf_pkg::ReqWrite, 2'd3, 6'd39, '1, 4'd4);
      send_request(drsf_pkg::ReqWrite, 2'd3, 6'd40, '1, 4'd3);
      send_request(drsf_pkg::ReqRead, 2'd3, 6'd41, '0, 4'd3);
      send_request(drsf_pkg::ReqUnused, 2'd1, 6'd0, '1, 4'd3);
      send_request(drsf_pkg::ReqWrite, 2'd1, 6'd5, '1, 4'd3);
      send_request(drsf_pkg::ReqRead, 2'd1, 6'd5, '0, 4'd0);
      send_request(drsf_pkg::ReqFlush, 2'd3, 6'd0, '0, 4'd0);
   endtask

   task automatic test_many_runs();
      // alternating dirty elements give the largest number of runs
      set_layout(7'd1, 7'd1, 7'd64);
      send_request(drsf_pkg::ReqFlush, 2'd0, 6'd0, '0, 4'd0);
      for (int i = 0; i < 64; i += 2)
         send_request(drsf_pkg::ReqWrite, 2'd0, 6'(i), rand_word(), 4'd1);
      send_request(drsf_pkg::ReqFlush, 2'd0, 6'd0, '0, 4'd0);
   endtask

   task automatic random_phase(int count, int gap, int stall);
      int nb, ec, es, pick;
      send_gap_pct = gap;
      rsp_stall_pct = stall;
      nb = nb_eff();
      ec = ec_eff();
      es = es_eff();
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(99);
         if (k == count / 2) drain_responses();
         if (pick < 88 && nb != 0 && ec != 0 && es != 0) begin
            if (pick < 45)
               send_request(drsf_pkg::ReqWrite, 2'($urandom_range(nb - 1)),
                            6'($urandom_range(ec - 1)), rand_word(), 4'(es));
            else if (pick < 78)
               send_request(drsf_pkg::ReqRead, 2'($urandom_range(nb - 1)),
                            6'($urandom_range(ec - 1)), rand_word(), 4'($urandom));
            else
               send_request(drsf_pkg::ReqFlush, 2'($urandom_range(nb - 1)), 6'($urandom),
                            rand_word(), 4'($urandom));
         end else begin
            send_request(2'($urandom), 2'($urandom), 6'($urandom), rand_word(), 4'($urandom));
         end
      end
   endtask

   task automatic test_random();
      set_layout(7'd2, 7'd3, 7'd17);
      random_phase(60, 12, 69);
      set_layout(7'd4, 7'd8, 7'd64);
      random_phase(45, 69, 12);
      set_layout(7'd7, 7'd15, 7'd127);
      random_phase(35, 0, 0);
      set_layout(7'd0, 7'd0, 7'd0);
      random_phase(15, 12, 69);
      set_layout(7'd1, 7'd1, 7'd1);
      random_phase(35, 69, 12);
      set_layout(7'd3, 7'd5, 7'd8);
      random_phase(70, 0, 0);
      set_layout(7'd4, 7'd2, 7'd24);
      random_phase(61, 12, 69);
   endtask

   initial begin
      buf_count_reg = 3'd1;
      elem_size_reg = 4'd8;
      elem_count_reg = 7'd64;
      for (int i = 0; i < drsf_pkg::Slots; i++) begin
         mirror_data[i] = '0;
         mirror_dirty[i] = 1'b1;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_flush();
      test_write_read();
      test_rejects();
      test_many_runs();
      test_random();
      drain_responses();
      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && pending_rsp.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
